FILE: sv/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

   // frame geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // field widths fixed by the interface
   localparam int DIM_W   = 11;
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int INDEX_W = 2;

   // counter widths
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int OROW_W = $clog2(MAX_HEIGHT);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
   localparam int LIM_W  = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                           $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
   localparam int CMP_W  = (LIM_W > DIM_W) ? LIM_W + 1 : DIM_W + 1;

   // arithmetic widths
   localparam int ABS_W  = 10;          // |gx|, |gy| <= 1020
   localparam int SQ_W   = 2 * ABS_W + 1;
   localparam int BIT_W  = $clog2(CHAN_W);

   // reset values of the registers
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   // register indexes
   localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = INDEX_W'(0);
   localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = INDEX_W'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_GRAD,
      S_SQUARE,
      S_ROOT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic update;
      logic grad;
      logic square;
      logic root;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic emit;
      logic root_last;
      logic out_busy;
   } status_type;

endpackage

FILE: sv/sem_if.sv
// ----------------------------------------------------------------------------
// sem_if
// Channel interfaces: pixel request, edge response and register write.
// ----------------------------------------------------------------------------
interface sem_req_if
   import sem_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic              flush;

   modport source (output valid, red, green, blue, flush, input ready);
   modport sink   (input valid, red, green, blue, flush, output ready);
endinterface

interface sem_rsp_if
   import sem_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] edge_red;
   logic [CHAN_W-1:0] edge_green;
   logic [CHAN_W-1:0] edge_blue;
   logic              last_of_frame;

   modport source (output valid, edge_red, edge_green, edge_blue, last_of_frame,
                   input ready);
   modport sink   (input valid, edge_red, edge_green, edge_blue, last_of_frame,
                   output ready);
endinterface

interface sem_csr_if
   import sem_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic [DIM_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/sem_ctrl.sv
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer: steps one beat through line read, gradient, square, root, load.
// ----------------------------------------------------------------------------
module sem_ctrl
   import sem_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd,
   output state_type  state
);
   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_READ;
         S_READ: begin
            if (status.skip || !status.emit) state_in = S_IDLE;
            else                             state_in = S_GRAD;
         end
         S_GRAD:   state_in = S_SQUARE;
         S_SQUARE: state_in = S_ROOT;
         S_ROOT:   if (status.root_last) state_in = S_DONE;
         S_DONE:   if (!status.out_busy) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_READ:   cmd.update = !status.skip;
         S_GRAD:   cmd.grad   = 1'b1;
         S_SQUARE: cmd.square = 1'b1;
         S_ROOT:   cmd.root   = 1'b1;
         S_DONE:   cmd.load   = !status.out_busy;
         default:  cmd        = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;
endmodule

FILE: sv/sem_dp.sv
// ----------------------------------------------------------------------------
// sem_dp
// Datapath: line buffers, 3x3 window, Sobel gradients and rounded root.
// ----------------------------------------------------------------------------
module sem_dp
   import sem_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [CHAN_W-1:0]  req_red,
   input  logic [CHAN_W-1:0]  req_green,
   input  logic [CHAN_W-1:0]  req_blue,
   input  logic               req_flush,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]   csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAN_W-1:0]  rsp_edge_red,
   output logic [CHAN_W-1:0]  rsp_edge_green,
   output logic [CHAN_W-1:0]  rsp_edge_blue,
   output logic               rsp_last_of_frame
);
   // configuration and position
   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [COL_W-1:0]  col_ff, ocol_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [OROW_W-1:0] orow_ff;
   logic [LIM_W-1:0]  w_lim, h_lim;

   // beat and window
   logic [PIX_W-1:0]  pix_ff;
   logic              skip_ff;
   logic [PIX_W-1:0]  win_ff [9];
   logic              zl_ff, zr_ff;
   logic [PIX_W-1:0]  l1_rd, l2_rd, top, mid;

   // arithmetic
   logic [ABS_W-1:0]  ax_ff [3];
   logic [ABS_W-1:0]  ay_ff [3];
   logic [ABS_W-1:0]  ax_in [3];
   logic [ABS_W-1:0]  ay_in [3];
   logic [SQ_W-1:0]   s_ff  [3];
   logic [CHAN_W-1:0] k_ff  [3];
   logic [CHAN_W-1:0] k_in  [3];
   logic [BIT_W-1:0]  bi_ff;

   // result register
   logic              out_valid_ff;
   logic [CHAN_W-1:0] out_ff [3];
   logic              out_last_ff;

   // step decode
   logic              in_frame, last_pos, emit, wrap, is_last, restart;
   logic [CMP_W-1:0]  col_next;
   logic              l2_we;

   // clamp register values to 1..MAX
   always_comb begin
      if (width_ff == '0)                     w_lim = LIM_W'(1);
      else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) w_lim = LIM_W'(MAX_WIDTH);
      else                                    w_lim = LIM_W'(width_ff);
      if (height_ff == '0)                    h_lim = LIM_W'(1);
      else if (CMP_W'(height_ff) > CMP_W'(MAX_HEIGHT)) h_lim = LIM_W'(MAX_HEIGHT);
      else                                    h_lim = LIM_W'(height_ff);
   end

   assign in_frame = CMP_W'(row_ff) < CMP_W'(h_lim);
   assign last_pos = (CMP_W'(row_ff) == CMP_W'(h_lim) + CMP_W'(1)) && (col_ff == '0);
   assign emit     = ((col_ff != '0) && (row_ff >= ROW_W'(1))) ||
                     ((col_ff == '0) && (row_ff >= ROW_W'(2)));
   assign col_next = CMP_W'(col_ff) + CMP_W'(1);
   assign wrap     = col_next >= CMP_W'(w_lim);
   assign top      = (row_ff >= ROW_W'(2)) ? l2_rd : '0;
   assign mid      = (row_ff >= ROW_W'(1)) ? l1_rd : '0;
   assign l2_we    = cmd.update && (row_ff >= ROW_W'(1));
   assign restart  = csr_valid && ((csr_index == REG_IMAGE_WIDTH) ||
                                   (csr_index == REG_IMAGE_HEIGHT));
   assign is_last  = (CMP_W'(orow_ff) == CMP_W'(h_lim) - CMP_W'(1)) &&
                     (CMP_W'(ocol_ff) == CMP_W'(w_lim) - CMP_W'(1));

   // line buffers, read at the current column
   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_one (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (col_ff),
      .wr_data (pix_ff),
      .rd_addr (col_ff),
      .rd_data (l1_rd)
   );

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two (
      .clock   (clock),
      .wr_en   (l2_we),
      .wr_addr (col_ff),
      .wr_data (mid),
      .rd_addr (col_ff),
      .rd_data (l2_rd)
   );

   // hold the beat; out-of-frame pixels count as black
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff  <= in_frame ? {req_red, req_green, req_blue} : '0;
         skip_ff <= in_frame && req_flush;
      end
   end

   // registers, positions, window, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         win_ff       <= '{default: '0};
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ready && !(cmd.load && !restart)) begin
            out_valid_ff <= 1'b0;
         end
         if (restart) begin
            if (csr_index == REG_IMAGE_WIDTH) width_ff  <= csr_data;
            else                              height_ff <= csr_data;
            col_ff  <= '0;
            row_ff  <= '0;
            ocol_ff <= '0;
            orow_ff <= '0;
            win_ff  <= '{default: '0};
         end else begin
            if (cmd.update) begin
               for (int k = 0; k < 6; k++) begin
                  win_ff[k] <= win_ff[k+3];
               end
               win_ff[6] <= top;
               win_ff[7] <= mid;
               win_ff[8] <= pix_ff;
               if (last_pos) begin
                  col_ff <= '0;
                  row_ff <= '0;
               end else if (wrap) begin
                  col_ff <= '0;
                  row_ff <= row_ff + ROW_W'(1);
               end else begin
                  col_ff <= col_next[COL_W-1:0];
               end
            end
            if (cmd.load) begin
               out_valid_ff <= 1'b1;
               if (is_last) begin
                  ocol_ff <= '0;
                  orow_ff <= '0;
               end else if (CMP_W'(ocol_ff) + CMP_W'(1) >= CMP_W'(w_lim)) begin
                  ocol_ff <= '0;
                  orow_ff <= orow_ff + OROW_W'(1);
               end else begin
                  ocol_ff <= ocol_ff + COL_W'(1);
               end
            end
         end
      end
   end

   // edge masks for the output pixel
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         zr_ff <= (col_ff == '0);
         zl_ff <= (col_ff == COL_W'(1)) || ((col_ff == '0) && (w_lim < LIM_W'(2)));
      end
   end

   // gradients per channel, edge columns forced black
   always_comb begin
      logic [CHAN_W-1:0] p [9];
      logic [ABS_W:0]    sa, sb, sc, sd;
      logic [ABS_W+1:0]  gx, gy;
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 9; k++) begin
            p[k] = win_ff[k][CHAN_W*(2-ch) +: CHAN_W];
            if ((k < 3 && zl_ff) || (k >= 6 && zr_ff)) p[k] = '0;
         end
         sa = (ABS_W+1)'(p[6]) + ((ABS_W+1)'(p[7]) << 1) + (ABS_W+1)'(p[8]);
         sb = (ABS_W+1)'(p[0]) + ((ABS_W+1)'(p[1]) << 1) + (ABS_W+1)'(p[2]);
         sc = (ABS_W+1)'(p[2]) + ((ABS_W+1)'(p[5]) << 1) + (ABS_W+1)'(p[8]);
         sd = (ABS_W+1)'(p[0]) + ((ABS_W+1)'(p[3]) << 1) + (ABS_W+1)'(p[6]);
         gx = (ABS_W+2)'(sa) - (ABS_W+2)'(sb);
         gy = (ABS_W+2)'(sc) - (ABS_W+2)'(sd);
         ax_in[ch] = gx[ABS_W+1] ? ABS_W'(-gx) : gx[ABS_W-1:0];
         ay_in[ch] = gy[ABS_W+1] ? ABS_W'(-gy) : gy[ABS_W-1:0];
      end
   end

   // one result bit per cycle: keep bit if s >= t*t - t + 1
   always_comb begin
      logic [CHAN_W-1:0]   t;
      logic [2*CHAN_W:0]   thr;
      for (int ch = 0; ch < 3; ch++) begin
         t   = k_ff[ch] | (CHAN_W'(1) << bi_ff);
         thr = (2*CHAN_W+1)'(t) * (2*CHAN_W+1)'(t) - (2*CHAN_W+1)'(t) +
               (2*CHAN_W+1)'(1);
         k_in[ch] = (s_ff[ch] >= SQ_W'(thr)) ? t : k_ff[ch];
      end
   end

   // gradient, square and root registers
   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
      if (cmd.square) begin
         for (int ch = 0; ch < 3; ch++) begin
            s_ff[ch] <= SQ_W'(ax_ff[ch]) * SQ_W'(ax_ff[ch]) +
                        SQ_W'(ay_ff[ch]) * SQ_W'(ay_ff[ch]);
            k_ff[ch] <= '0;
         end
         bi_ff <= BIT_W'(CHAN_W - 1);
      end
      if (cmd.root) begin
         k_ff  <= k_in;
         bi_ff <= bi_ff - BIT_W'(1);
      end
      if (cmd.load) begin
         out_ff      <= k_ff;
         out_last_ff <= is_last;
      end
   end

   assign status.skip      = skip_ff;
   assign status.emit      = emit;
   assign status.root_last = (bi_ff == '0);
   assign status.out_busy  = out_valid_ff && !rsp_ready;

   assign csr_ready         = 1'b1;
   assign rsp_valid         = out_valid_ff;
   assign rsp_edge_red      = out_ff[0];
   assign rsp_edge_green    = out_ff[1];
   assign rsp_edge_blue     = out_ff[2];
   assign rsp_last_of_frame = out_last_ff;
endmodule

FILE: sv/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel gradient magnitude on RGB pixels in raster order.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  req_bus   in   red, green, blue, flush (pixel or drain beat)
//  rsp_bus   out  edge_red, edge_green, edge_blue, last_of_frame
//  csr_bus   in   index (0 width, 1 height), data
//
//  A beat that yields a result passes the line buffer read, gradient,
//  square and the bit-per-cycle rounded root over its eight bits, then
//  the load into the result register; only then is the next beat taken.
//  A beat with no result frees the input after the line buffer read. The
//  load waits while the result register holds a beat that is not yet
//  taken, and the input stalls with it.
//  Reset is synchronous; it restores 640x480 and restarts the frame.
//  A write to the width or height register restarts the frame; writes are always accepted.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb
   import sem_pkg::*;
(
   input logic       clock,
   input logic       reset,
   sem_req_if.sink   req_bus,
   sem_rsp_if.source rsp_bus,
   sem_csr_if.sink   csr_bus
);
   cmd_type    cmd;
   status_type status;
   state_type  state;

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   sem_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_red           (req_bus.red),
      .req_green         (req_bus.green),
      .req_blue          (req_bus.blue),
      .req_flush         (req_bus.flush),
      .csr_valid         (csr_bus.valid),
      .csr_ready         (csr_bus.ready),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_edge_red      (rsp_bus.edge_red),
      .rsp_edge_green    (rsp_bus.edge_green),
      .rsp_edge_blue     (rsp_bus.edge_blue),
      .rsp_last_of_frame (rsp_bus.last_of_frame)
   );

   // one beat at a time
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("second beat accepted while one is in work");

   // a finished root loads a result once the register is free
   a_load: assert property (@(posedge clock) disable iff (reset)
      state == S_DONE && !(rsp_bus.valid && !rsp_bus.ready) |=> rsp_bus.valid)
      else $error("result not loaded");

   // root runs exactly until its last bit
   a_root: assert property (@(posedge clock) disable iff (reset)
      state == S_ROOT && !status.root_last |=> state == S_ROOT)
      else $error("root left early");
endmodule

FILE: sim/sobel_edge_magnitude_rgb_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_tb
// Self-checking bench: drives RGB frames of many sizes through the Sobel block,
// predicts each edge beat (bit-true model, or given in a directed row), compares them.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_tb;
   import sem_pkg::*;

   localparam int                 CLK_HALF    = 10;
   localparam int                 WATCHDOG    = 5000;
   localparam int                 LONG_HOLD   = 400;
   localparam int                 SETTLE      = 20;
   localparam int                 TOTAL_BEATS = 600;
   localparam logic [INDEX_W-1:0] REG_UNUSED  = INDEX_W'(3);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
   } edge_beat_type;

   typedef struct {
      bit                 is_cfg;
      logic [INDEX_W-1:0] index;
      logic [DIM_W-1:0]   data;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic               flush;
      bit                 typed;
      edge_beat_type      want;
   } stim_row_type;

   logic clock;
   logic reset;

   sem_req_if req_bus ();
   sem_rsp_if rsp_bus ();
   sem_csr_if csr_bus ();

   sobel_edge_magnitude_rgb i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   logic [PIX_W-1:0] line_prev2 [MAX_WIDTH];
   logic [PIX_W-1:0] line_prev1 [MAX_WIDTH];
   logic [PIX_W-1:0] nbhd [9];
   int               next_col, next_row, emit_col, emit_row;

   edge_beat_type edge_queue [$];
   int            error_count;
   int            beat_count;
   int            edge_count;
   int            frame_count;
   int            idle_cycles;
   bit            no_idle;
   bit            hold_request;
   stim_row_type  directed_rows [$];

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   function automatic int clamp_dim(input logic [DIM_W-1:0] raw, input int hi);
      if (raw == 0) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   // rounded square root of gx^2 + gy^2 for one channel, capped at 255
   function automatic logic [CHAN_W-1:0] channel_magnitude(input logic [PIX_W-1:0] t [9],
                                                           input int sh);
      int p [9];
      int gx, gy, s, r;
      for (int k = 0; k < 9; k++) p[k] = (t[k] >> sh) & 8'hFF;
      gx = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
      gy = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
      s  = gx * gx + gy * gy;
      r  = 0;
      for (int b = 11; b >= 0; b--) begin
         if ((r | (1 << b)) * (r | (1 << b)) <= s) r = r | (1 << b);
      end
      if (s > r * r + r) r++;
      return (r > 255) ? 8'd255 : CHAN_W'(r);
   endfunction

   function automatic void restart_frame();
      for (int k = 0; k < 9; k++) nbhd[k] = '0;
      next_col = 0;
      next_row = 0;
      emit_col = 0;
      emit_row = 0;
   endfunction

   // advance the frame by one accepted beat; returns 1 when it yields an edge beat
   function automatic bit sobel_step(input logic [CHAN_W-1:0] rr, gg, bb,
                                     input logic fl, output edge_beat_type res);
      int               w, h, r, c, pc;
      logic [PIX_W-1:0] top, mid, bot;
      logic [PIX_W-1:0] t [9];
      bit               emit, last_pos;
      w   = clamp_dim(width_reg, MAX_WIDTH);
      h   = clamp_dim(height_reg, MAX_HEIGHT);
      r   = next_row;
      c   = next_col;
      top = '0;
      mid = '0;
      bot = '0;
      res = '0;
      // drop a drain beat while pixels are still due
      if (r < h && fl) return 0;
      if (r < h) bot = {rr, gg, bb};
      if (r >= 2) top = line_prev2[c];
      if (r >= 1) begin
         mid = line_prev1[c];
         line_prev2[c] = mid;
      end
      line_prev1[c] = bot;
      for (int k = 0; k < 6; k++) nbhd[k] = nbhd[k+3];
      nbhd[6] = top;
      nbhd[7] = mid;
      nbhd[8] = bot;
      emit     = (c >= 1 && r >= 1) || (c == 0 && r >= 2);
      last_pos = (r == h + 1 && c == 0);
      if (last_pos) begin
         next_row = 0;
         next_col = 0;
      end else begin
         c++;
         if (c >= w) begin
            c = 0;
            r++;
         end
         next_col = c;
         next_row = r;
      end
      if (!emit) return 0;
      t = nbhd;
      // black out the columns that fall off the image edges
      pc = last_pos ? 0 : ((next_col == 0) ? w - 1 : next_col - 1);
      if (pc == 0) begin
         t[6] = '0; t[7] = '0; t[8] = '0;
         if (w < 2) begin
            t[0] = '0; t[1] = '0; t[2] = '0;
         end
      end else if (pc == 1) begin
         t[0] = '0; t[1] = '0; t[2] = '0;
      end
      res.red   = channel_magnitude(t, 16);
      res.green = channel_magnitude(t, 8);
      res.blue  = channel_magnitude(t, 0);
      res.last  = (emit_row == h - 1 && emit_col == w - 1);
      if (res.last) begin
         emit_row = 0;
         emit_col = 0;
      end else begin
         emit_col++;
         if (emit_col >= w) begin
            emit_col = 0;
            emit_row++;
         end
      end
      return 1;
   endfunction

   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic logic [CHAN_W-1:0] pixel_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // present one pixel or drain beat, hold until taken, then predict
   task automatic send_beat(input logic [CHAN_W-1:0] rr, gg, bb, input logic fl,
                            input bit typed, input edge_beat_type want);
      int            gap;
      edge_beat_type res;
      gap = idle_draw();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.red   <= rr;
      req_bus.green <= gg;
      req_bus.blue  <= bb;
      req_bus.flush <= fl;
      do @(posedge clock); while (!req_bus.ready);
      beat_count++;
      if (sobel_step(rr, gg, bb, fl, res)) edge_queue.push_back(typed ? want : res);
   endtask

   // hold the input until every pending edge beat is out and the pipe is empty
   task automatic drain_all();
      req_bus.valid <= 1'b0;
      while (edge_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DIM_W-1:0] val);
      drain_all();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) begin
         width_reg = val;
         restart_frame();
      end else if (idx == REG_IMAGE_HEIGHT) begin
         height_reg = val;
         restart_frame();
      end
   endtask

   // one frame of random content; optionally cut short, noisy, with a pause or a result hold-off
   task automatic run_frame(input logic [DIM_W-1:0] w_raw, h_raw, input bit noisy,
                            input int cut_at, input int pause_at, input int hold_at);
      int w, h, n;
      w = clamp_dim(w_raw, MAX_WIDTH);
      h = clamp_dim(h_raw, MAX_HEIGHT);
      write_reg(REG_IMAGE_WIDTH, w_raw);
      write_reg(REG_IMAGE_HEIGHT, h_raw);
      n = 0;
      for (int p = 0; p < w * h + w + 1; p++) begin
         if (n == cut_at) return;
         if (n == pause_at) drain_all();
         if (n == hold_at) hold_request = 1'b1;
         if (p < w * h) begin
            if (noisy && $urandom_range(0, 9) == 0)
               send_beat(pixel_value(), pixel_value(), pixel_value(), 1'b1, 0, '0);
            send_beat(pixel_value(), pixel_value(), pixel_value(), 1'b0, 0, '0);
         end else begin
            // drain with either a flush or a pixel whose data is discarded
            send_beat(pixel_value(), pixel_value(), pixel_value(),
                      (!noisy || $urandom_range(0, 2) != 0), 0, '0);
         end
         n++;
      end
      frame_count++;
   endtask

   // result side: random stalls, one long hold-off on request, check each beat
   initial begin
      int            gap;
      edge_beat_type want;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            gap = LONG_HOLD;
         end else begin
            gap = idle_draw();
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         edge_count++;
         if (edge_queue.size() == 0) begin
            note_error("edge beat with none expected");
         end else begin
            want = edge_queue.pop_front();
            if (rsp_bus.edge_red !== want.red || rsp_bus.edge_green !== want.green ||
                rsp_bus.edge_blue !== want.blue || rsp_bus.last_of_frame !== want.last)
               note_error($sformatf("edge rgb/last exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                  want.red, want.green, want.blue, want.last, rsp_bus.edge_red,
                  rsp_bus.edge_green, rsp_bus.edge_blue, rsp_bus.last_of_frame));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("Timeout: no handshake for %0d cycles", WATCHDOG);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // main stimulus
   initial begin
      stim_row_type row;
      int           w_rand, h_rand;
      req_bus.valid <= 1'b0;
      req_bus.red   <= '0;
      req_bus.green <= '0;
      req_bus.blue  <= '0;
      req_bus.flush <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data  <= '0;
      error_count  = 0;
      beat_count   = 0;
      edge_count   = 0;
      frame_count  = 0;
      idle_cycles  = 0;
      no_idle      = 0;
      hold_request = 0;
      width_reg    = WIDTH_RESET;
      height_reg   = HEIGHT_RESET;
      for (int k = 0; k < MAX_WIDTH; k++) begin
         line_prev1[k] = '0;
         line_prev2[k] = '0;
      end
      restart_frame();

      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero registers clamp to a 1x1 frame whose only edge is flat
      directed_rows.push_back('{1, REG_IMAGE_WIDTH, 11'd0, 0, 0, 0, 0, 0, '0});
      directed_rows.push_back('{1, REG_IMAGE_HEIGHT, 11'd0, 0, 0, 0, 0, 0, '0});
      directed_rows.push_back('{0, 0, 0, 8'd255, 8'd255, 8'd255, 0, 0, '0});
      directed_rows.push_back('{0, 0, 0, 8'd0, 8'd0, 8'd0, 1, 0, '0});
      // pixel past the frame acts as a drain beat and closes the frame
      directed_rows.push_back('{0, 0, 0, 8'd12, 8'd34, 8'd56, 0, 1,
                                '{8'd0, 8'd0, 8'd0, 1'b1}});
      directed_rows.push_back('{1, REG_UNUSED, 11'h7FF, 0, 0, 0, 0, 0, '0});
      directed_rows.push_back('{1, REG_IMAGE_WIDTH, 11'd3, 0, 0, 0, 0, 0, '0});
      directed_rows.push_back('{1, REG_IMAGE_HEIGHT, 11'd3, 0, 0, 0, 0, 0, '0});
      // flush inside the pixel part is ignored
      directed_rows.push_back('{0, 0, 0, 8'd9, 8'd9, 8'd9, 1, 0, '0});
      for (int k = 0; k < 9; k++)
         directed_rows.push_back('{0, 0, 0, (k % 2) ? 8'd0 : 8'd255,
                                   (k < 3) ? 8'd255 : 8'd0, (k % 3 == 1) ? 8'd255 : 8'd1,
                                   0, 0, '0});
      for (int k = 0; k < 4; k++)
         directed_rows.push_back('{0, 0, 0, 8'd77, 8'd0, 8'd255, (k != 2), 0, '0});

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) write_reg(row.index, row.data);
         else send_beat(row.red, row.green, row.blue, row.flush, row.typed, row.want);
      end

      // extremes: start of the widest row with clamped width, of the tallest column
      run_frame(11'h7FF, 11'd1, 0, 150, -1, -1);
      run_frame(11'd1, 11'h7FF, 0, 100, -1, -1);
      // small frame under a long result hold-off
      run_frame(11'd2, 11'd2, 0, -1, -1, 1);

      // random frames, mostly complete, some noisy or cut short
      while (beat_count < TOTAL_BEATS) begin
         no_idle = ($urandom_range(0, 5) == 0);
         w_rand  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
         h_rand  = $urandom_range(1, 9);
         run_frame(DIM_W'(w_rand), DIM_W'(h_rand), ($urandom_range(0, 3) == 0),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, w_rand * h_rand) : -1,
                   ($urandom_range(0, 5) == 0) ? $urandom_range(1, w_rand * h_rand) : -1,
                   (frame_count % 9 == 4) ? 1 : -1);
      end

      // restore the reset geometry through the port and finish idle
      write_reg(REG_IMAGE_WIDTH, WIDTH_RESET);
      write_reg(REG_IMAGE_HEIGHT, HEIGHT_RESET);
      drain_all();

      $display("Covered %0d input beats, %0d edge beats, %0d complete frames,",
               beat_count, edge_count, frame_count);
      $display("sizes from 1x1 to partial clamped 1024-wide and 1024-tall frames, with stalls.");
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: sobel_edge_magnitude_rgb.f
sv/sem_pkg.sv
sv/sem_if.sv
sv/sem_ram.sv
sv/sem_ctrl.sv
sv/sem_dp.sv
sv/sobel_edge_magnitude_rgb.sv
sim/sobel_edge_magnitude_rgb_tb.sv
